// ----- sv/tbdc_pkg.sv -----
// Shared types and constants of the two-beam direction counter.
// Holds edge and event codes, register indexes, reset values and the channel status type.
// No dependencies.
package tbdc_pkg;

  localparam int ThrBits  = 10;
  localparam int TickBits = 8;
  localparam int MinBits  = 16;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;
  localparam int PulseOutBits = 32;
  localparam int CountBits = 8;

  localparam logic [ThrBits-1:0]  HighThrReset = 10'd640;
  localparam logic [ThrBits-1:0]  LowThrReset  = 10'd384;
  localparam logic [TickBits-1:0] TickMsReset  = 8'd5;
  localparam logic [MinBits-1:0]  MinPulseReset = 16'd100;
  localparam logic [CountBits-1:0] CountMax = 8'd255;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_CH1_HIGH = 3'd0,
    CFG_CH1_LOW  = 3'd1,
    CFG_CH2_HIGH = 3'd2,
    CFG_CH2_LOW  = 3'd3,
    CFG_TICK_MS  = 3'd4,
    CFG_MIN_MS   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_FALL = 2'd1,
    EDGE_RISE = 2'd2
  } edge_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_BOARD   = 3'd1,
    EV_ALIGHT  = 3'd2,
    EV_REFUSED = 3'd3,
    EV_SHORT   = 3'd4
  } event_e;

  typedef struct packed {
    edge_e kind;
    logic  done;
  } ch_status_t;

endpackage

// ----- sv/tbdc_channel.sv -----
// One beam channel: hysteresis edge detection, edge time stamps and pulse forming.
// Depends on tbdc_pkg.
module tbdc_channel #(
  parameter int SAMPLE_BITS = 10,
  parameter int TIME_BITS   = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        primed_i,
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  input  logic [tbdc_pkg::ThrBits-1:0]  high_thr_i,
  input  logic [tbdc_pkg::ThrBits-1:0]  low_thr_i,
  input  logic [tbdc_pkg::TickBits-1:0] tick_ms_i,
  input  logic [TIME_BITS-1:0]        stamp_i,
  output tbdc_pkg::ch_status_t        status_o,
  output logic [TIME_BITS-1:0]        width_o,
  output logic [TIME_BITS-1:0]        start_o
);

  localparam int CmpW = (SAMPLE_BITS > tbdc_pkg::ThrBits) ? SAMPLE_BITS : tbdc_pkg::ThrBits;

  logic [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [TIME_BITS-1:0]   fall_q, fall_d, rise_q, rise_d;
  logic                   fall_seen_q, fall_seen_d, rise_seen_q, rise_seen_d;

  logic [CmpW-1:0] cur, prev, hi, lo;
  logic            active, outside, is_fall, is_rise, done;
  logic [TIME_BITS-1:0] diff;
  logic [TIME_BITS+tbdc_pkg::TickBits-1:0] prod;

  assign cur  = CmpW'(sample_i);
  assign prev = CmpW'(prev_q);
  assign hi   = CmpW'(high_thr_i);
  assign lo   = CmpW'(low_thr_i);

  assign active  = step_i && primed_i;
  assign outside = (cur > hi) || (cur < lo);
  assign is_fall = active && (cur < lo) && (prev > hi);
  assign is_rise = active && (cur > hi) && (prev < lo);

  assign fall_d = is_fall ? stamp_i : fall_q;
  assign rise_d = is_rise ? stamp_i : rise_q;

  // Both edges seen on an outside-band tick form a pulse and re-arm the channel.
  assign done = active && outside && (fall_seen_q || is_fall) && (rise_seen_q || is_rise);
  assign fall_seen_d = done ? 1'b0 : (fall_seen_q || is_fall);
  assign rise_seen_d = done ? 1'b0 : (rise_seen_q || is_rise);

  always_comb begin
    prev_d = prev_q;
    if (step_i && (!primed_i || outside)) begin
      prev_d = sample_i;
    end
  end

  assign diff = rise_d - fall_d;
  assign prod = diff * tick_ms_i;
  assign width_o = prod[TIME_BITS-1:0];
  assign start_o = fall_d;

  always_comb begin
    status_o.kind = tbdc_pkg::EDGE_NONE;
    if (is_rise) begin
      status_o.kind = tbdc_pkg::EDGE_RISE;
    end else if (is_fall) begin
      status_o.kind = tbdc_pkg::EDGE_FALL;
    end
    status_o.done = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      fall_q      <= '0;
      rise_q      <= '0;
      fall_seen_q <= 1'b0;
      rise_seen_q <= 1'b0;
    end else if (step_i) begin
      prev_q      <= prev_d;
      fall_q      <= fall_d;
      rise_q      <= rise_d;
      fall_seen_q <= fall_seen_d;
      rise_seen_q <= rise_seen_d;
    end
  end

  // A pulse is formed in the same beat that completes it, so both flags never linger.
  a_seen_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fall_seen_q && rise_seen_q))
    else $error("channel holds both edges without forming a pulse");

  a_done_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (step_i && primed_i && outside))
    else $error("pulse formed on an inactive or in-band beat");

endmodule

// ----- sv/two_beam_direction_counter_top.sv -----
// Top level of the two-beam direction counter: input register, two channels,
// pair judgment, occupancy count and output register. Depends on tbdc_pkg and tbdc_channel.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  input   | in_valid_i / in_ready_o | sample_ch1_i, sample_ch2_i
//  output  | out_valid_o/out_ready_i | ch1/ch2_edge_o, ch1/ch2_pulse_ms_o,
//          |                        | event_res_o, passenger_count_o
//  config  | cfg_we_i               | cfg_index_i, cfg_data_i
//
// One beat is accepted per cycle unless the output stalls; it waits in the input register,
// is judged by logic whose depth is set by the width multiply and the minimum-width
// compare, and its result goes to the output register. Reset clears flow, edge and count
// state and loads config defaults; the first beat after reset only primes the previous
// samples. A stalled output holds its result while the input register takes one more beat.
module two_beam_direction_counter_top #(
  parameter int SAMPLE_BITS = 10,
  parameter int TIME_BITS   = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tbdc_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [tbdc_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [SAMPLE_BITS-1:0]         sample_ch1_i,
  input  logic [SAMPLE_BITS-1:0]         sample_ch2_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     ch1_edge_o,
  output logic [1:0]                     ch2_edge_o,
  output logic [tbdc_pkg::PulseOutBits-1:0] ch1_pulse_ms_o,
  output logic [tbdc_pkg::PulseOutBits-1:0] ch2_pulse_ms_o,
  output logic [2:0]                     event_res_o,
  output logic [tbdc_pkg::CountBits-1:0] passenger_count_o
);

  // Configuration registers.
  logic [tbdc_pkg::ThrBits-1:0]  hi1_q, lo1_q, hi2_q, lo2_q;
  logic [tbdc_pkg::TickBits-1:0] tick_ms_q;
  logic [tbdc_pkg::MinBits-1:0]  min_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi1_q     <= tbdc_pkg::HighThrReset;
      lo1_q     <= tbdc_pkg::LowThrReset;
      hi2_q     <= tbdc_pkg::HighThrReset;
      lo2_q     <= tbdc_pkg::LowThrReset;
      tick_ms_q <= tbdc_pkg::TickMsReset;
      min_ms_q  <= tbdc_pkg::MinPulseReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tbdc_pkg::CFG_CH1_HIGH: hi1_q     <= cfg_data_i[tbdc_pkg::ThrBits-1:0];
        tbdc_pkg::CFG_CH1_LOW:  lo1_q     <= cfg_data_i[tbdc_pkg::ThrBits-1:0];
        tbdc_pkg::CFG_CH2_HIGH: hi2_q     <= cfg_data_i[tbdc_pkg::ThrBits-1:0];
        tbdc_pkg::CFG_CH2_LOW:  lo2_q     <= cfg_data_i[tbdc_pkg::ThrBits-1:0];
        tbdc_pkg::CFG_TICK_MS:  tick_ms_q <= cfg_data_i[tbdc_pkg::TickBits-1:0];
        tbdc_pkg::CFG_MIN_MS:   min_ms_q  <= cfg_data_i[tbdc_pkg::MinBits-1:0];
        default: ;
      endcase
    end
  end

  // Input register and stage flow.
  logic                   in_full_q;
  logic [SAMPLE_BITS-1:0] s1_q, s2_q;
  logic                   advance, step;

  assign advance    = !out_valid_o || out_ready_i;
  assign step       = in_full_q && advance;
  assign in_ready_o = !in_full_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_full_q <= 1'b1;
    end else if (step) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= sample_ch1_i;
      s2_q <= sample_ch2_i;
    end
  end

  // Tick stamp and priming.
  logic [TIME_BITS-1:0] tick_q, stamp;
  logic                 primed_q;

  assign stamp = tick_q + TIME_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      primed_q <= 1'b0;
    end else if (step) begin
      tick_q   <= stamp;
      primed_q <= 1'b1;
    end
  end

  // Channels.
  tbdc_pkg::ch_status_t st1, st2;
  logic [TIME_BITS-1:0] w1, w2, start1, start2;

  tbdc_channel #(.SAMPLE_BITS(SAMPLE_BITS), .TIME_BITS(TIME_BITS)) u_ch1 (
    .clk_i, .rst_ni,
    .step_i(step), .primed_i(primed_q), .sample_i(s1_q),
    .high_thr_i(hi1_q), .low_thr_i(lo1_q), .tick_ms_i(tick_ms_q), .stamp_i(stamp),
    .status_o(st1), .width_o(w1), .start_o(start1)
  );

  tbdc_channel #(.SAMPLE_BITS(SAMPLE_BITS), .TIME_BITS(TIME_BITS)) u_ch2 (
    .clk_i, .rst_ni,
    .step_i(step), .primed_i(primed_q), .sample_i(s2_q),
    .high_thr_i(hi2_q), .low_thr_i(lo2_q), .tick_ms_i(tick_ms_q), .stamp_i(stamp),
    .status_o(st2), .width_o(w2), .start_o(start2)
  );

  // Pair judgment.
  logic [TIME_BITS-1:0] len_q [2];
  logic [TIME_BITS-1:0] len_d [2];
  logic [TIME_BITS-1:0] pstart_q [2];
  logic [TIME_BITS-1:0] pstart_d [2];
  logic [TIME_BITS-1:0] min_ext, dstart;
  logic [tbdc_pkg::CountBits-1:0] occ_q, occ_d;
  tbdc_pkg::event_e     event_d;

  assign min_ext = TIME_BITS'(min_ms_q);

  always_comb begin
    len_d[0]    = st1.done ? w1 : len_q[0];
    len_d[1]    = st2.done ? w2 : len_q[1];
    pstart_d[0] = st1.done ? start1 : pstart_q[0];
    pstart_d[1] = st2.done ? start2 : pstart_q[1];
    dstart      = pstart_d[0] - pstart_d[1];
    occ_d       = occ_q;
    event_d     = tbdc_pkg::EV_NONE;
    if (primed_q && (len_d[0] != '0) && (len_d[1] != '0)) begin
      if ((len_d[0] > min_ext) && (len_d[1] > min_ext)) begin
        // Channel two broken first means the person walked in.
        if ((dstart != '0) && !dstart[TIME_BITS-1]) begin
          event_d = tbdc_pkg::EV_BOARD;
          if (occ_q != tbdc_pkg::CountMax) begin
            occ_d = occ_q + 1'b1;
          end
        end else if (occ_q != '0) begin
          event_d = tbdc_pkg::EV_ALIGHT;
          occ_d   = occ_q - 1'b1;
        end else begin
          event_d = tbdc_pkg::EV_REFUSED;
        end
      end else begin
        event_d = tbdc_pkg::EV_SHORT;
      end
      len_d[0] = '0;
      len_d[1] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q[0]    <= '0;
      len_q[1]    <= '0;
      pstart_q[0] <= '0;
      pstart_q[1] <= '0;
      occ_q       <= '0;
    end else if (step) begin
      len_q[0]    <= len_d[0];
      len_q[1]    <= len_d[1];
      pstart_q[0] <= pstart_d[0];
      pstart_q[1] <= pstart_d[1];
      occ_q       <= occ_d;
    end
  end

  // Output register.
  logic [63:0] w1_ext, w2_ext;

  assign w1_ext = st1.done ? 64'(w1) : 64'd0;
  assign w2_ext = st2.done ? 64'(w2) : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= in_full_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      ch1_edge_o        <= st1.kind;
      ch2_edge_o        <= st2.kind;
      ch1_pulse_ms_o    <= w1_ext[tbdc_pkg::PulseOutBits-1:0];
      ch2_pulse_ms_o    <= w2_ext[tbdc_pkg::PulseOutBits-1:0];
      event_res_o       <= event_d;
      passenger_count_o <= occ_d;
    end
  end

  a_len_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((len_q[0] != '0) && (len_q[1] != '0)))
    else $error("two held pulses were left unjudged");

  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q != $past(occ_q)) |->
      ((occ_q == $past(occ_q) + 1'b1) || (occ_q == $past(occ_q) - 1'b1)))
    else $error("occupancy moved by more than one");

  a_board_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o == tbdc_pkg::EV_BOARD)) |-> (passenger_count_o != '0))
    else $error("boarding reported with an empty count");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o == tbdc_pkg::EV_REFUSED)) |-> (passenger_count_o == '0))
    else $error("refused alighting reported with a nonzero count");

endmodule
